// ===== rtl/lbnco_pkg.sv =====
package lbnco_pkg;

  localparam int CHANNELS_DEF   = 15;
  localparam int PHASE_BITS_DEF = 16;

  localparam int COS_BITS     = 10;
  localparam int QUARTER_BITS = COS_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;

  localparam int COLOURS   = 3;
  localparam int MAX_LEDS  = 8;
  localparam int LED_W     = 3;
  localparam int VALUE_W   = 16;
  localparam int AMP_W     = 8;
  localparam int MAG_W     = 15;
  localparam int FACTOR_W  = 17;
  localparam int CHAN_W    = 4;
  localparam int MAP_ROW_W = 3;
  localparam int COLOUR_W  = 2;

  localparam int FRAME_LEN = 17;
  localparam int LAST_SLOT = FRAME_LEN - 1;
  localparam int SLOT_W    = 5;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [AMP_W-1:0]    FRAME_HEAD = 8'h20;
  localparam logic [AMP_W-1:0]    AMP_RESET  = 8'd127;
  localparam logic [FACTOR_W-1:0] Q15_ONE    = 17'd32768;
  localparam logic [63:0]         HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_PHASE = 2'd1,
    OP_SET_INC   = 2'd2,
    OP_SET_AMP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [LED_W-1:0]   led;
    logic [VALUE_W-1:0] red;
    logic [VALUE_W-1:0] green;
    logic [VALUE_W-1:0] blue;
  } cmd_t;

  typedef struct packed {
    logic                 has_chan;
    logic [CHAN_W-1:0]    chan;
    logic [MAP_ROW_W-1:0] row;
    logic [COLOUR_W-1:0]  colour;
  } slot_map_t;

  // Frame slot to channel, in the expander's register order.
  function automatic slot_map_t slot_map(input logic [SLOT_W-1:0] slot);
    slot_map_t m;
    m = '0;
    case (slot)
      5'd1:    m = '{1'b1, 4'd8,  3'd2, 2'd2};
      5'd2:    m = '{1'b1, 4'd9,  3'd3, 2'd0};
      5'd3:    m = '{1'b1, 4'd10, 3'd3, 2'd1};
      5'd4:    m = '{1'b1, 4'd11, 3'd3, 2'd2};
      5'd5:    m = '{1'b1, 4'd0,  3'd0, 2'd0};
      5'd6:    m = '{1'b1, 4'd1,  3'd0, 2'd1};
      5'd7:    m = '{1'b1, 4'd2,  3'd0, 2'd2};
      5'd8:    m = '{1'b1, 4'd3,  3'd1, 2'd0};
      5'd9:    m = '{1'b1, 4'd4,  3'd1, 2'd1};
      5'd10:   m = '{1'b1, 4'd5,  3'd1, 2'd2};
      5'd11:   m = '{1'b1, 4'd6,  3'd2, 2'd0};
      5'd12:   m = '{1'b1, 4'd7,  3'd2, 2'd1};
      5'd13:   m = '{1'b1, 4'd12, 3'd4, 2'd0};
      5'd14:   m = '{1'b1, 4'd13, 3'd4, 2'd1};
      5'd15:   m = '{1'b1, 4'd14, 3'd4, 2'd2};
      default: m = '0;
    endcase
    return m;
  endfunction

  // Q15 magnitude of cos or sin over one quarter turn, from a nine-term
  // Taylor series in Q30. Evaluated at elaboration only.
  function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned r,
                                                   input bit want_sin);
    logic [63:0]        theta;
    logic [63:0]        x2;
    logic [63:0]        tc;
    logic [63:0]        ts;
    logic signed [63:0] sc;
    logic signed [63:0] ss;
    logic signed [63:0] m;
    logic [63:0]        q;
    theta = (64'(r) * HALF_PI_Q30) >> QUARTER_BITS;
    x2 = (theta * theta) >> 30;
    tc = 64'd1 << 30;
    ts = theta;
    sc = signed'(tc);
    ss = signed'(ts);
    tc = ((tc * x2) >> 30) / 64'd2;
    ts = ((ts * x2) >> 30) / 64'd6;
    sc = sc - signed'(tc);
    ss = ss - signed'(ts);
    tc = ((tc * x2) >> 30) / 64'd12;
    ts = ((ts * x2) >> 30) / 64'd20;
    sc = sc + signed'(tc);
    ss = ss + signed'(ts);
    tc = ((tc * x2) >> 30) / 64'd30;
    ts = ((ts * x2) >> 30) / 64'd42;
    sc = sc - signed'(tc);
    ss = ss - signed'(ts);
    tc = ((tc * x2) >> 30) / 64'd56;
    ts = ((ts * x2) >> 30) / 64'd72;
    sc = sc + signed'(tc);
    ss = ss + signed'(ts);
    tc = ((tc * x2) >> 30) / 64'd90;
    ts = ((ts * x2) >> 30) / 64'd110;
    sc = sc - signed'(tc);
    ss = ss - signed'(ts);
    tc = ((tc * x2) >> 30) / 64'd132;
    ts = ((ts * x2) >> 30) / 64'd156;
    sc = sc + signed'(tc);
    ss = ss + signed'(ts);
    tc = ((tc * x2) >> 30) / 64'd182;
    ts = ((ts * x2) >> 30) / 64'd210;
    sc = sc - signed'(tc);
    ss = ss - signed'(ts);
    tc = ((tc * x2) >> 30) / 64'd240;
    ts = ((ts * x2) >> 30) / 64'd272;
    sc = sc + signed'(tc);
    ss = ss + signed'(ts);
    m = want_sin ? ss : sc;
    if (m < 0) begin
      m = 0;
    end
    q = (unsigned'(m) + (64'd1 << 14)) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/lbnco_front.sv =====
module lbnco_front #(
  parameter int ROWS = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [1:0]          s_axis_tuser,   // op
  input  logic [55:0]         s_axis_tdata,   // led, red_value, green_value, blue_value
  output logic                q_valid,
  input  logic                q_ready,
  output lbnco_pkg::cmd_t     q_cmd
);

  logic            fv;
  logic            fkeep;
  lbnco_pkg::cmd_t fcmd;
  logic            f_done;
  logic            in_keep;
  lbnco_pkg::op_t  in_op;

  assign in_op   = lbnco_pkg::op_t'(s_axis_tuser);
  // Loads that address an LED with no channels are dropped here.
  assign in_keep = (in_op == lbnco_pkg::OP_TICK) ||
                   ({1'b0, s_axis_tdata[2:0]} < (lbnco_pkg::LED_W + 1)'(ROWS));

  assign f_done        = fv && (!fkeep || q_ready);
  assign s_axis_tready = !fv || f_done;
  assign q_valid       = fv && fkeep;
  assign q_cmd         = fcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      fv <= 1'b1;
    end else if (f_done) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      fkeep      <= in_keep;
      fcmd.op    <= in_op;
      fcmd.led   <= s_axis_tdata[2:0];
      fcmd.red   <= s_axis_tdata[18:3];
      fcmd.green <= s_axis_tdata[34:19];
      fcmd.blue  <= s_axis_tdata[50:35];
    end
  end

endmodule

// ===== rtl/lbnco_queue.sv =====
module lbnco_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lbnco_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lbnco_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = (lbnco_pkg::QUEUE_DEPTH > 1) ? $clog2(lbnco_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lbnco_pkg::QUEUE_DEPTH + 1);

  lbnco_pkg::cmd_t  entry [lbnco_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(lbnco_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(lbnco_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(lbnco_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/lbnco_back.sv =====
module lbnco_back #(
  parameter int CHANNELS   = 15,
  parameter int PHASE_BITS = 16,
  parameter int ROWS       = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  lbnco_pkg::cmd_t q_cmd,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata,   // frame_byte, byte_index
  output logic            m_axis_tlast
);

  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COS_W   = lbnco_pkg::COS_BITS;
  localparam int QB      = lbnco_pkg::QUARTER_BITS;
  localparam int AMP_W   = lbnco_pkg::AMP_W;
  localparam int FAC_W   = lbnco_pkg::FACTOR_W;
  localparam int PROD_W  = AMP_W + FAC_W;
  localparam int SLOT_W  = lbnco_pkg::SLOT_W;
  localparam int NCOL    = lbnco_pkg::COLOURS;
  localparam int CMP_W   = 7;

  logic [PHASE_BITS-1:0] phase [ROWS][NCOL];
  logic [PHASE_BITS-1:0] inc   [ROWS][NCOL];
  logic [AMP_W-1:0]      amp   [ROWS][NCOL];

  logic [lbnco_pkg::MAG_W-1:0] cos_rom [lbnco_pkg::QUARTER];
  logic [lbnco_pkg::MAG_W-1:0] sin_rom [lbnco_pkg::QUARTER];

  logic              busy;
  logic [SLOT_W-1:0] cnt;

  logic                  advance;
  logic                  head_tick;
  logic                  start;
  logic                  load;
  logic                  issue;
  logic [SLOT_W-1:0]     issue_slot;
  lbnco_pkg::slot_map_t  map;
  logic                  chan_ok;
  logic [ROW_W-1:0]      rd_row;
  logic [1:0]            rd_col;
  logic [ROW_W-1:0]      ld_row;
  logic [PHASE_BITS-1:0] cur_phase;
  logic [PHASE_BITS-1:0] cur_inc;
  logic [AMP_W-1:0]      cur_amp;
  logic [31:0]           ld_wide [NCOL];

  logic                  s1_valid;
  logic [SLOT_W-1:0]     s1_slot;
  logic                  s1_ok;
  logic [PHASE_BITS-1:0] s1_phase;
  logic [AMP_W-1:0]      s1_amp;

  logic [COS_W-1:0]            cos_idx;
  logic [1:0]                  quad;
  logic [QB-1:0]               qpos;
  logic [lbnco_pkg::MAG_W-1:0] mag;
  logic                        neg;
  logic [FAC_W-1:0]            factor;

  logic              s2_valid;
  logic [SLOT_W-1:0] s2_slot;
  logic              s2_ok;
  logic [AMP_W-1:0]  s2_amp;
  logic [FAC_W-1:0]  s2_factor;

  logic              s3_valid;
  logic [SLOT_W-1:0] s3_slot;
  logic              s3_ok;
  logic [PROD_W-1:0] s3_prod;

  logic [PROD_W-16:0] scaled;
  logic [AMP_W-1:0]   sat_byte;
  logic [AMP_W-1:0]   byte_next;

  logic              out_valid;
  logic [AMP_W-1:0]  out_byte;
  logic [SLOT_W-1:0] out_slot;
  logic              out_last;

  for (genvar g = 0; g < lbnco_pkg::QUARTER; g++) begin : g_rom
    assign cos_rom[g] = lbnco_pkg::quarter_mag(g, 1'b0);
    assign sin_rom[g] = lbnco_pkg::quarter_mag(g, 1'b1);
  end

  assign advance    = !out_valid || m_axis_tready;
  assign head_tick  = q_cmd.op == lbnco_pkg::OP_TICK;
  assign start      = !busy && q_valid && head_tick && advance;
  assign load       = !busy && q_valid && !head_tick;
  assign issue      = (busy && advance) || start;
  assign q_ready    = start || load;
  assign issue_slot = busy ? cnt : '0;

  assign map     = lbnco_pkg::slot_map(issue_slot);
  assign chan_ok = map.has_chan && (CMP_W'(map.chan) < CMP_W'(CHANNELS));
  assign rd_row  = ROW_W'(map.row);
  assign rd_col  = map.colour;
  assign ld_row  = ROW_W'(q_cmd.led);

  assign cur_phase = phase[rd_row][rd_col];
  assign cur_inc   = inc[rd_row][rd_col];
  assign cur_amp   = amp[rd_row][rd_col];

  assign ld_wide[0] = 32'(q_cmd.red);
  assign ld_wide[1] = 32'(q_cmd.green);
  assign ld_wide[2] = 32'(q_cmd.blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < NCOL; c++) begin
          phase[r][c] <= '0;
          inc[r][c]   <= '0;
          amp[r][c]   <= lbnco_pkg::AMP_RESET;
        end
      end
    end else begin
      if (load) begin
        for (int c = 0; c < NCOL; c++) begin
          case (q_cmd.op)
            lbnco_pkg::OP_SET_PHASE: phase[ld_row][c] <= ld_wide[c][PHASE_BITS-1:0];
            lbnco_pkg::OP_SET_INC:   inc[ld_row][c]   <= ld_wide[c][PHASE_BITS-1:0];
            lbnco_pkg::OP_SET_AMP:   amp[ld_row][c]   <= ld_wide[c][AMP_W-1:0];
            default: ;
          endcase
        end
      end
      if (issue && chan_ok) begin
        phase[rd_row][rd_col] <= cur_phase + cur_inc;
      end
      if (start) begin
        busy <= 1'b1;
        cnt  <= SLOT_W'(1);
      end else if (busy && advance) begin
        if (cnt == SLOT_W'(lbnco_pkg::LAST_SLOT)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  if (PHASE_BITS >= COS_W) begin : g_idx_hi
    assign cos_idx = s1_phase[PHASE_BITS-1 -: COS_W];
  end else begin : g_idx_lo
    assign cos_idx = {s1_phase, {(COS_W - PHASE_BITS){1'b0}}};
  end

  assign quad   = cos_idx[COS_W-1 -: 2];
  assign qpos   = cos_idx[QB-1:0];
  assign mag    = quad[0] ? sin_rom[qpos] : cos_rom[qpos];
  assign neg    = (quad == 2'd1) || (quad == 2'd2);
  assign factor = neg ? (lbnco_pkg::Q15_ONE + FAC_W'(mag)) : (lbnco_pkg::Q15_ONE - FAC_W'(mag));

  assign scaled   = s3_prod[PROD_W-1:15];
  assign sat_byte = (scaled > (PROD_W - 15)'(255)) ? 8'hFF : scaled[AMP_W-1:0];

  always_comb begin
    if (s3_slot == '0) begin
      byte_next = lbnco_pkg::FRAME_HEAD;
    end else if (!s3_ok) begin
      byte_next = '0;
    end else begin
      byte_next = sat_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_slot   <= issue_slot;
      s1_ok     <= chan_ok;
      s1_phase  <= cur_phase;
      s1_amp    <= cur_amp;
      s2_slot   <= s1_slot;
      s2_ok     <= s1_ok;
      s2_amp    <= s1_amp;
      s2_factor <= factor;
      s3_slot   <= s2_slot;
      s3_ok     <= s2_ok;
      s3_prod   <= PROD_W'(s2_amp) * PROD_W'(s2_factor);
      out_byte  <= byte_next;
      out_slot  <= s3_slot;
      out_last  <= s3_slot == SLOT_W'(lbnco_pkg::LAST_SLOT);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_slot, out_byte};
  assign m_axis_tlast  = out_last;

endmodule

// ===== rtl/multi_channel_led_breathing_nco.sv =====
// Channel   Direction  Word
// s_axis    in         tuser op; tdata led, red_value, green_value, blue_value
// m_axis    out        tdata frame_byte, byte_index; tlast on byte 16
//
// A tick issues 17 frame bytes from the channel tables, one per cycle while the
// output is not stalled; each byte passes the s1, s2 (cosine lookup), s3
// (multiply) and output registers. Reset returns every phase and increment to
// zero and every amplitude to 127 in the reset cycle. A stalled output freezes
// tick issue and the pipeline, though loads are still taken between ticks; the
// input register and the two-entry command queue go on taking words.
module multi_channel_led_breathing_nco #(
  parameter int CHANNELS   = lbnco_pkg::CHANNELS_DEF,
  parameter int PHASE_BITS = lbnco_pkg::PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // op
  input  logic [55:0] s_axis_tdata,   // led, red_value, green_value, blue_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // frame_byte, byte_index
  output logic        m_axis_tlast
);

  localparam int ROWS = ((CHANNELS + 2) / 3 > lbnco_pkg::MAX_LEDS) ?
                        lbnco_pkg::MAX_LEDS : (CHANNELS + 2) / 3;

  logic            push_valid;
  logic            push_ready;
  lbnco_pkg::cmd_t push_cmd;
  logic            pop_valid;
  logic            pop_ready;
  lbnco_pkg::cmd_t pop_cmd;

  lbnco_front #(
    .ROWS (ROWS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (push_valid),
    .q_ready       (push_ready),
    .q_cmd         (push_cmd)
  );

  lbnco_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lbnco_back #(
    .CHANNELS   (CHANNELS),
    .PHASE_BITS (PHASE_BITS),
    .ROWS       (ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (pop_valid),
    .q_ready       (pop_ready),
    .q_cmd         (pop_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tlast == (m_axis_tdata[12:8] == 5'(lbnco_pkg::LAST_SLOT))))
    else $error("tlast does not match the final frame position");

  a_head_byte: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[12:8] == 5'd0)) |->
      (m_axis_tdata[7:0] == lbnco_pkg::FRAME_HEAD))
    else $error("frame does not open with the header byte");

  a_no_early_head: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      !(m_axis_tvalid && (m_axis_tdata[12:8] == 5'd0)))
    else $error("new frame started before the previous one ended");

  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && !pop_ready && !push_ready) |=> pop_valid)
    else $error("queue lost a pending command");
`endif

endmodule

// ===== verif/breathing_frame_checker.sv =====
module breathing_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // op
  input  logic [55:0] s_axis_tdata,   // led, red_value, green_value, blue_value
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // frame_byte, byte_index
  input  logic        m_axis_tlast,
  output int          mismatch_count,
  output int          words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CHAN = 15;
  localparam int FRAME_WORDS = 17;
  localparam logic [7:0] HEAD_BYTE = 8'h20;
  localparam logic [7:0] AMP_AT_RESET = 8'd127;
  localparam longint unsigned HALF_PI_Q30_C = 64'd1686629713;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [4:0] byte_index;
    logic       last;
  } frame_word_t;

  logic [15:0] phase_acc [NUM_CHAN];
  logic [15:0] phase_inc [NUM_CHAN];
  logic [7:0]  amplitude [NUM_CHAN];
  frame_word_t expected_words [$];

  // Q15 magnitude of cos (or sin) over one quarter turn, nine-term series in Q30.
  function automatic int unsigned series_mag(input int unsigned r, input bit want_sin);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term_c;
    longint unsigned term_s;
    longint unsigned mag;
    longint sum_c;
    longint sum_s;
    longint pick;
    int n;
    ang = (64'(r) * HALF_PI_Q30_C) >> 8;
    ang_sq = (ang * ang) >> 30;
    term_c = 64'd1 << 30;
    term_s = ang;
    sum_c = longint'(term_c);
    sum_s = longint'(term_s);
    for (n = 1; n <= 8; n++) begin
      term_c = ((term_c * ang_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
      term_s = ((term_s * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum_c = sum_c - longint'(term_c);
        sum_s = sum_s - longint'(term_s);
      end else begin
        sum_c = sum_c + longint'(term_c);
        sum_s = sum_s + longint'(term_s);
      end
    end
    pick = want_sin ? sum_s : sum_c;
    if (pick < 0) begin
      pick = 0;
    end
    mag = (64'(pick) + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return 32'(mag);
  endfunction

  function automatic int cosine_q15(input logic [9:0] k);
    int unsigned mag;
    mag = series_mag(int'(k[7:0]), k[8]);
    if (k[9:8] == 2'd1 || k[9:8] == 2'd2) begin
      return -int'(mag);
    end
    return int'(mag);
  endfunction

  function automatic logic [7:0] led_level(input logic [15:0] ph, input logic [7:0] amp);
    int cv;
    int unsigned lvl;
    cv = cosine_q15(ph[15:6]);
    lvl = (int'(amp) * (32768 - cv)) >> 15;
    return (lvl > 255) ? 8'hFF : 8'(lvl);
  endfunction

  function automatic int slot_channel(input int slot);
    if (slot >= 1 && slot <= 4) begin
      return slot + 7;
    end
    if (slot >= 5 && slot <= 12) begin
      return slot - 5;
    end
    if (slot >= 13 && slot <= 15) begin
      return slot - 1;
    end
    return -1;
  endfunction

  task automatic apply_word(input lbnco_pkg::op_t op, input logic [2:0] led,
                            input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b);
    logic [15:0] vals [3];
    logic [7:0] level [NUM_CHAN];
    frame_word_t w;
    int c;
    int ch;
    int s;
    vals[0] = r;
    vals[1] = g;
    vals[2] = b;
    if (op != lbnco_pkg::OP_TICK) begin
      for (c = 0; c < 3; c++) begin
        ch = 3 * int'(led) + c;
        if (ch < NUM_CHAN) begin
          case (op)
            lbnco_pkg::OP_SET_PHASE: phase_acc[ch] = vals[c];
            lbnco_pkg::OP_SET_INC: phase_inc[ch] = vals[c];
            default: amplitude[ch] = vals[c][7:0];
          endcase
        end
      end
    end else begin
      for (ch = 0; ch < NUM_CHAN; ch++) begin
        level[ch] = led_level(phase_acc[ch], amplitude[ch]);
        phase_acc[ch] = phase_acc[ch] + phase_inc[ch];
      end
      for (s = 0; s < FRAME_WORDS; s++) begin
        ch = slot_channel(s);
        w.byte_index = 5'(s);
        w.last = (s == FRAME_WORDS - 1);
        if (s == 0) begin
          w.frame_byte = HEAD_BYTE;
        end else if (ch >= 0 && ch < NUM_CHAN) begin
          w.frame_byte = level[ch];
        end else begin
          w.frame_byte = 8'h00;
        end
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic check_word();
    frame_word_t want;
    if (expected_words.size() == 0) begin
      $error("unexpected output word: tdata %0h, tlast %0b", m_axis_tdata, m_axis_tlast);
      mismatch_count++;
    end else begin
      want = expected_words.pop_front();
      if (m_axis_tdata[7:0] !== want.frame_byte) begin
        $error("frame_byte: expected %0h, got %0h", want.frame_byte, m_axis_tdata[7:0]);
        mismatch_count++;
      end
      if (m_axis_tdata[12:8] !== want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, m_axis_tdata[12:8]);
        mismatch_count++;
      end
      if (m_axis_tlast !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        phase_acc[i] = '0;
        phase_inc[i] = '0;
        amplitude[i] = AMP_AT_RESET;
      end
      expected_words.delete();
      mismatch_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_word();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_word(lbnco_pkg::op_t'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[18:3],
                   s_axis_tdata[34:19], s_axis_tdata[50:35]);
      end
    end
    words_due = expected_words.size();
  end

endmodule

// ===== verif/multi_channel_led_breathing_nco_tb.sv =====
module multi_channel_led_breathing_nco_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CMDS = 87;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = lbnco_pkg::OP_TICK;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        steady = 1'b0;
  int          mismatch_count;
  int          words_due;
  int          cycles = 0;
  int          ticks = 0;
  int          loads = 0;

  multi_channel_led_breathing_nco u_dut (.*);

  breathing_frame_checker u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_cmd(input lbnco_pkg::op_t op, input logic [2:0] led,
                          input logic [15:0] r, input logic [15:0] g,
                          input logic [15:0] b);
    while (!steady && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'd0, b, g, r, led};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == lbnco_pkg::OP_TICK) begin
      ticks++;
    end else begin
      loads++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000 | 16'($urandom_range(0, 63));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    lbnco_pkg::op_t op;
    logic [2:0] led;
    int accepted;
    bit paused;
    accepted = 0;
    paused = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(lbnco_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(lbnco_pkg::OP_SET_AMP, 3'd0, 16'hFFFF, 16'h0000, 16'h80AB);
    send_cmd(lbnco_pkg::OP_SET_PHASE, 3'd0, 16'h8000, 16'h4000, 16'h0000);
    send_cmd(lbnco_pkg::OP_TICK, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(lbnco_pkg::OP_SET_AMP, 3'd1, 16'h00FF, 16'hFF7F, 16'h0001);
    send_cmd(lbnco_pkg::OP_SET_AMP, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(lbnco_pkg::OP_SET_AMP, 3'd3, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(lbnco_pkg::OP_SET_AMP, 3'd4, 16'h5555, 16'hAAAA, 16'h00C3);
    send_cmd(lbnco_pkg::OP_SET_PHASE, 3'd1, 16'hFFFF, 16'hC000, 16'h2000);
    send_cmd(lbnco_pkg::OP_SET_PHASE, 3'd2, 16'h7FFF, 16'h8040, 16'h3FC0);
    send_cmd(lbnco_pkg::OP_SET_PHASE, 3'd4, 16'hAAAA, 16'h5555, 16'hFFC0);
    send_cmd(lbnco_pkg::OP_SET_INC, 3'd0, 16'hFFFF, 16'h0001, 16'h8000);
    send_cmd(lbnco_pkg::OP_SET_INC, 3'd2, 16'h0400, 16'hFC00, 16'h0040);
    send_cmd(lbnco_pkg::OP_SET_INC, 3'd4, 16'h5555, 16'hAAAA, 16'hFFFF);
    send_cmd(lbnco_pkg::OP_TICK, 3'd7, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(lbnco_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(lbnco_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(lbnco_pkg::OP_SET_PHASE, 3'd5, 16'h1234, 16'hFFFF, 16'h0000);
    send_cmd(lbnco_pkg::OP_SET_INC, 3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(lbnco_pkg::OP_SET_AMP, 3'd7, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_cmd(lbnco_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(lbnco_pkg::OP_SET_AMP, 3'd4, 16'h0000, 16'hFF00, 16'h0000);
    send_cmd(lbnco_pkg::OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000);

    while (accepted < RANDOM_CMDS) begin
      steady <= (accepted >= 60 && accepted < 85);
      if ($urandom_range(0, 99) < 35) begin
        op = lbnco_pkg::OP_TICK;
      end else begin
        op = lbnco_pkg::op_t'($urandom_range(1, 3));
      end
      if ($urandom_range(0, 9) == 0) begin
        led = 3'($urandom_range(5, 7));
      end else begin
        led = 3'($urandom_range(0, 4));
      end
      send_cmd(op, led, pick_value(), pick_value(), pick_value());
      accepted++;
      if (accepted == 50 && !paused) begin
        drain();
        paused = 1;
      end
    end

    steady <= 1'b0;
    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d commands (%0d frame ticks, %0d table loads) under random stalls.",
             ticks + loads, ticks, loads);
    if (mismatch_count == 0 && words_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
